### src/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Types, constants and helpers shared by the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int POS_BITS_DEFAULT = 16;

   localparam int RADIX_W  = 6;
   localparam int VALUE_W  = 64;
   localparam int OFFSET_W = 16;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MODE   = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [5:0] {
      PH_SKIP   = 6'b000001,
      PH_SIGNED = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_HEX    = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               signed_mode;
      logic               wide_mode;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] end_offset;
      logic                converted;
      logic                range_error;
   } result_type;

   // digit value, DIGIT_NONE for anything not alphanumeric
   function automatic logic [RADIX_W-1:0] digit_value(input logic [7:0] c);
      logic [RADIX_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = RADIX_W'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d = RADIX_W'(c - CH_LA) + BASE_DEC;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d = RADIX_W'(c - CH_UA) + BASE_DEC;
      end
      return d;
   endfunction

endpackage

### src/aip_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface aip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [15:0] end_offset;
   logic        converted;
   logic        range_error;

   modport source (output valid, output value, output end_offset, output converted,
                   output range_error, input ready);
   modport sink   (input valid, input value, input end_offset, input converted,
                   input range_error, output ready);
endinterface

### src/aip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_core
// Per-character parse step: phase tracking, multiply-accumulate with
// saturation check, subject end tracking and result formation.
// ----------------------------------------------------------------------------
module aip_core
   import aip_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] ch,
   input  logic       last,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int EXT_BITS = (POS_BITS > OFFSET_W) ? POS_BITS : OFFSET_W;
   localparam int PROD_W   = VALUE_W + RADIX_W + 1;

   phase_type            phase_ff, phase_in;
   logic [VALUE_W-1:0]   magnitude_ff, magnitude_in;
   logic                 negative_ff, negative_in;
   logic [RADIX_W-1:0]   base_ff, base_in;
   logic                 digit_seen_ff, digit_seen_in;
   logic                 overflowed_ff, overflowed_in;
   logic [POS_BITS-1:0]  position_ff, position_in;
   logic [POS_BITS-1:0]  subject_end_ff, subject_end_in;

   logic [RADIX_W-1:0]   digit;
   logic                 is_space;
   logic                 start;
   logic                 accumulate;
   logic                 bad_radix;
   logic                 zero_prefix;
   logic [RADIX_W-1:0]   start_base;
   logic [RADIX_W-1:0]   acc_base;
   logic [VALUE_W-1:0]   abs_limit;
   logic [PROD_W-1:0]    product;
   logic [POS_BITS-1:0]  mark;
   logic                 final_ovf;
   logic [VALUE_W-1:0]   final_value;
   logic [EXT_BITS-1:0]  end_ext;

   assign digit      = digit_value(ch);
   assign is_space   = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   assign bad_radix  = (cfg.radix == RADIX_ONE) || (cfg.radix > RADIX_MAX);
   assign zero_prefix = (ch == CH_ZERO)
                        && (cfg.radix == RADIX_AUTO || cfg.radix == BASE_HEX);
   assign start_base = (cfg.radix == RADIX_AUTO) ? BASE_DEC : cfg.radix;
   assign acc_base   = start ? start_base : base_ff;

   always_comb begin
      if (cfg.signed_mode) begin
         abs_limit = cfg.wide_mode ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};
      end else begin
         abs_limit = cfg.wide_mode ? '1 : {32'd0, 32'hFFFF_FFFF};
      end
   end

   assign product = PROD_W'(magnitude_ff) * PROD_W'(acc_base) + PROD_W'(digit);
   assign mark    = (position_ff == '1) ? position_ff : position_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      magnitude_in   = magnitude_ff;
      negative_in    = negative_ff;
      base_in        = base_ff;
      digit_seen_in  = digit_seen_ff;
      overflowed_in  = overflowed_ff;
      subject_end_in = subject_end_ff;
      start          = 1'b0;
      accumulate     = 1'b0;

      unique case (phase_ff)
         PH_SKIP: begin
            if (is_space) begin
               phase_in = PH_SKIP;
            end else if (ch == CH_MINUS) begin
               if (cfg.signed_mode) begin
                  negative_in = 1'b1;
                  phase_in    = PH_SIGNED;
               end else begin
                  phase_in = PH_DONE;
               end
            end else if (ch == CH_PLUS) begin
               phase_in = PH_SIGNED;
            end else begin
               start = 1'b1;
            end
         end
         PH_SIGNED: begin
            start = 1'b1;
         end
         PH_ZERO: begin
            if (ch == CH_LX || ch == CH_UX) begin
               base_in  = BASE_HEX;
               phase_in = PH_HEX;
            end else if (digit < base_ff) begin
               accumulate = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_HEX, PH_DIGITS: begin
            if (digit < base_ff) begin
               accumulate = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (start) begin
         if (bad_radix) begin
            phase_in = PH_DONE;
         end else if (zero_prefix) begin
            base_in        = (cfg.radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
            digit_seen_in  = 1'b1;
            magnitude_in   = '0;
            subject_end_in = mark;
            phase_in       = PH_ZERO;
         end else begin
            base_in = start_base;
            if (digit < start_base) begin
               accumulate = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end

      if (accumulate) begin
         if (!overflowed_ff) begin
            if (product > PROD_W'(abs_limit)) begin
               overflowed_in = 1'b1;
            end else begin
               magnitude_in = product[VALUE_W-1:0];
            end
         end
         digit_seen_in  = 1'b1;
         subject_end_in = mark;
         phase_in       = PH_DIGITS;
      end
   end

   assign position_in = mark;

   // result seen on the last character of a string
   always_comb begin
      final_ovf = overflowed_in
                  || (cfg.signed_mode && !negative_in && magnitude_in == abs_limit);
      if (final_ovf) begin
         if (cfg.signed_mode) begin
            final_value = negative_in ? '0 - abs_limit : abs_limit - 1'b1;
         end else begin
            final_value = abs_limit;
         end
      end else begin
         final_value = negative_in ? '0 - magnitude_in : magnitude_in;
      end
      end_ext = EXT_BITS'(subject_end_in);
      if (digit_seen_in) begin
         result.value       = final_value;
         result.end_offset  = end_ext[OFFSET_W-1:0];
         result.converted   = 1'b1;
         result.range_error = final_ovf;
      end else begin
         result.value       = '0;
         result.end_offset  = '0;
         result.converted   = 1'b0;
         result.range_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff       <= PH_SKIP;
         magnitude_ff   <= '0;
         negative_ff    <= 1'b0;
         base_ff        <= '0;
         digit_seen_ff  <= 1'b0;
         overflowed_ff  <= 1'b0;
         position_ff    <= '0;
         subject_end_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         magnitude_ff   <= magnitude_in;
         negative_ff    <= negative_in;
         base_ff        <= base_in;
         digit_seen_ff  <= digit_seen_in;
         overflowed_ff  <= overflowed_in;
         position_ff    <= position_in;
         subject_end_ff <= subject_end_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> phase_ff == PH_SKIP && position_ff == '0 && !digit_seen_ff)
      else $error("parse state not cleared after last item");

   a_ovf_has_digit: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> digit_seen_ff)
      else $error("overflow without any digit");

   a_digits_seen: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGITS || phase_ff == PH_ZERO || phase_ff == PH_HEX)
      |-> digit_seen_ff)
      else $error("digit phase without digit");

   a_end_in_range: assert property (@(posedge clock) disable iff (reset)
      subject_end_ff <= position_ff)
      else $error("subject end beyond position");
`endif

endmodule

### src/aip_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_out_reg
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module aip_out_reg
   import aip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   aip_rsp_if.source  rsp_chan
);

   logic       valid_ff;
   result_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.value       = data_ff.value;
   assign rsp_chan.end_offset  = data_ff.end_offset;
   assign rsp_chan.converted   = data_ff.converted;
   assign rsp_chan.range_error = data_ff.range_error;

endmodule

### src/ascii_integer_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_top
// Streaming strtol/strtoul-style integer parser, one character per item.
// ----------------------------------------------------------------------------
// Characters enter one per cycle through an input register; each is folded
// into the running value by one 64x6 multiply-add and limit compare, so the
// block sustains one item per clock with no gaps between strings. The item
// flagged last loads one result into the output register; input stalls only
// while that register holds an untaken result and a last item is waiting.
// Registers radix, signed_mode, wide_mode are written by csr_we/csr_index/
// csr_wdata; the user must do so only while idle; the block does not check.
// ----------------------------------------------------------------------------
module ascii_integer_parser_top
   import aip_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   aip_req_if.sink              req_chan,
   aip_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RADIX_W-1:0]   csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       out_free;
   logic       step;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix       <= RADIX_RESET;
         cfg_ff.signed_mode <= 1'b1;
         cfg_ff.wide_mode   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIX:       cfg_ff.radix       <= csr_wdata;
            CSR_SIGNED_MODE: cfg_ff.signed_mode <= csr_wdata[0];
            CSR_WIDE_MODE:   cfg_ff.wide_mode   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign step           = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_ch_ff   <= req_chan.ch;
         in_last_ff <= req_chan.last;
      end
   end

   aip_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .ch     (in_ch_ff),
      .last   (in_last_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   aip_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && in_last_ff),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
